// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/les_pkg.sv =====
// ---------------------------------------------------------------------------
// Looping event sequencer package
// Action and result codes, register indexes, and the command and status
// types that join the controller to the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package les_pkg;

   localparam int EVENT_SLOTS_DEF   = 16;
   localparam int ONE_OFF_SLOTS_DEF = 8;

   localparam logic [3:0] ACT_ADD     = 4'd0;
   localparam logic [3:0] ACT_REMOVE  = 4'd1;
   localparam logic [3:0] ACT_MOVE    = 4'd2;
   localparam logic [3:0] ACT_ONE_OFF = 4'd3;
   localparam logic [3:0] ACT_SET     = 4'd4;
   localparam logic [3:0] ACT_UPDATE  = 4'd5;
   localparam logic [3:0] ACT_TRIGGER = 4'd6;
   localparam logic [3:0] ACT_START   = 4'd7;
   localparam logic [3:0] ACT_STOP    = 4'd8;
   localparam logic [3:0] ACT_QUERY   = 4'd9;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_EVENT   = 2'd1;
   localparam logic [1:0] KIND_ONE_OFF = 2'd2;

   localparam logic [1:0] REG_LOOP_BEGIN  = 2'd0;
   localparam logic [1:0] REG_LOOP_LENGTH = 2'd1;
   localparam logic [1:0] REG_LOOPING     = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LATCH    = 4'd1,
      OP_SCAN     = 4'd2,
      OP_APPLY    = 4'd3,
      OP_SETPOS   = 4'd4,
      OP_MOD      = 4'd5,
      OP_MOD_FIN  = 4'd6,
      OP_FIRE_OO  = 4'd7,
      OP_FIRE_EV  = 4'd8,
      OP_TRIG_END = 4'd9,
      OP_NEXT_SUM = 4'd10,
      OP_STATUS   = 4'd11
   } dp_op_type;

   typedef enum logic [2:0] {
      SCAN_FIND  = 3'd0,
      SCAN_OOSEL = 3'd1,
      SCAN_AHEAD = 3'd2,
      SCAN_EVSEL = 3'd3,
      SCAN_NEXT  = 3'd4
   } scan_mode_type;

   typedef struct packed {
      dp_op_type     op;
      scan_mode_type mode;
   } dp_cmd_type;

   typedef struct packed {
      logic playing;
      logic scan_last;
      logic mod_last;
      logic sel_found;
      logic skip_here;
      logic any_ahead;
      logic looping;
      logic pos_same;
      logic pos_wrap;
   } dp_stat_type;

endpackage

// ===== src/les_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sequencer controller
// Steps each transaction through its scans, updates and result emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module les_ctrl
   import les_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [3:0]  req_action,
   input  dp_stat_type stat,
   output logic        busy,
   output dp_cmd_type  cmd
);

   typedef enum logic [15:0] {
      S_IDLE      = 16'b0000_0000_0000_0001,
      S_FIND      = 16'b0000_0000_0000_0010,
      S_APPLY     = 16'b0000_0000_0000_0100,
      S_SETPOS    = 16'b0000_0000_0000_1000,
      S_MOD       = 16'b0000_0000_0001_0000,
      S_MOD_FIN   = 16'b0000_0000_0010_0000,
      S_OO_SCAN   = 16'b0000_0000_0100_0000,
      S_OO_DEC    = 16'b0000_0000_1000_0000,
      S_AHEAD     = 16'b0000_0001_0000_0000,
      S_AHEAD_DEC = 16'b0000_0010_0000_0000,
      S_EV_SCAN   = 16'b0000_0100_0000_0000,
      S_EV_DEC    = 16'b0000_1000_0000_0000,
      S_TRIG_END  = 16'b0001_0000_0000_0000,
      S_NEXT      = 16'b0010_0000_0000_0000,
      S_NEXT_SUM  = 16'b0100_0000_0000_0000,
      S_STATUS    = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      saved_update_ff, saved_update_in;
   logic      saved_set_ff, saved_set_in;
   logic      need_find;

   assign busy = (state_ff != S_IDLE);
   assign need_find = (req_action == ACT_ADD) || (req_action == ACT_REMOVE) ||
                      (req_action == ACT_MOVE) || (req_action == ACT_QUERY);

   always_comb begin
      state_in        = state_ff;
      saved_update_in = saved_update_ff;
      saved_set_in    = saved_set_ff;
      cmd.op          = OP_NONE;
      cmd.mode        = SCAN_FIND;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               saved_set_in    = (req_action == ACT_SET);
               saved_update_in = (req_action == ACT_UPDATE);
               if (need_find) begin
                  state_in = S_FIND;
               end else if (req_action == ACT_TRIGGER) begin
                  state_in = S_OO_SCAN;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_FIND: begin
            cmd.op = OP_SCAN;
            cmd.mode = SCAN_FIND;
            if (stat.scan_last) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.op = OP_APPLY;
            // Set position always takes the position path; update only does so
            // while playing.
            state_in = (saved_set_ff || (saved_update_ff && stat.playing)) ? S_SETPOS
                                                                           : S_NEXT;
         end
         S_SETPOS: begin
            cmd.op = OP_SETPOS;
            state_in = (!stat.pos_same && stat.pos_wrap) ? S_MOD : S_NEXT;
         end
         S_MOD: begin
            cmd.op = OP_MOD;
            if (stat.mod_last) state_in = S_MOD_FIN;
         end
         S_MOD_FIN: begin
            cmd.op = OP_MOD_FIN;
            state_in = S_NEXT;
         end
         S_OO_SCAN: begin
            cmd.op = OP_SCAN;
            cmd.mode = SCAN_OOSEL;
            if (stat.scan_last) state_in = S_OO_DEC;
         end
         S_OO_DEC: begin
            if (stat.sel_found) begin
               cmd.op = OP_FIRE_OO;
               state_in = S_OO_SCAN;
            end else begin
               state_in = stat.skip_here ? S_TRIG_END : S_AHEAD;
            end
         end
         S_AHEAD: begin
            cmd.op = OP_SCAN;
            cmd.mode = SCAN_AHEAD;
            if (stat.scan_last) state_in = S_AHEAD_DEC;
         end
         S_AHEAD_DEC: begin
            state_in = (stat.any_ahead || stat.looping) ? S_EV_SCAN : S_TRIG_END;
         end
         S_EV_SCAN: begin
            cmd.op = OP_SCAN;
            cmd.mode = SCAN_EVSEL;
            if (stat.scan_last) state_in = S_EV_DEC;
         end
         S_EV_DEC: begin
            if (stat.sel_found) begin
               cmd.op = OP_FIRE_EV;
               state_in = S_EV_SCAN;
            end else begin
               state_in = S_TRIG_END;
            end
         end
         S_TRIG_END: begin
            cmd.op = OP_TRIG_END;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.op = OP_SCAN;
            cmd.mode = SCAN_NEXT;
            if (stat.scan_last) state_in = S_NEXT_SUM;
         end
         S_NEXT_SUM: begin
            cmd.op = OP_NEXT_SUM;
            state_in = S_STATUS;
         end
         S_STATUS: begin
            cmd.op = OP_STATUS;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         saved_update_ff <= 1'b0;
         saved_set_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         saved_update_ff <= saved_update_in;
         saved_set_ff    <= saved_set_in;
      end
   end

endmodule

// ===== src/les_datapath.sv =====
// ---------------------------------------------------------------------------
// Sequencer datapath
// Event and one-off tables, position state, slot scanner, serial remainder
// unit and the registered result port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module les_datapath
   import les_pkg::*;
#(
   parameter int EVENT_SLOTS   = EVENT_SLOTS_DEF,
   parameter int ONE_OFF_SLOTS = ONE_OFF_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [3:0]  req_action,
   input  logic [15:0] req_event_id,
   input  logic [31:0] req_position,
   input  logic [31:0] req_duration,
   input  logic [7:0]  req_tag,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic        rsp_ok,
   output logic [15:0] rsp_fired_id,
   output logic [7:0]  rsp_fired_tag,
   output logic [31:0] rsp_now_position,
   output logic [31:0] rsp_time_to_next,
   output logic        rsp_is_playing,
   output logic        rsp_last
);

   localparam int MAX_SLOTS = (EVENT_SLOTS > ONE_OFF_SLOTS) ? EVENT_SLOTS : ONE_OFF_SLOTS;
   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int OW = (ONE_OFF_SLOTS > 1) ? $clog2(ONE_OFF_SLOTS) : 1;
   localparam logic [SW-1:0] SCAN_LAST = SW'(MAX_SLOTS - 1);
   localparam logic [5:0]    MOD_LAST  = 6'd32;
   localparam logic [31:0]   ALL32     = 32'hFFFF_FFFF;
   localparam logic [31:0]   NEAR_ALL  = 32'hFFFF_FFFE;

   // Configuration.
   logic [31:0] begin_ff, begin_in, len_ff, len_in;
   logic        looping_ff, looping_in;
   logic [31:0] eff_len;

   // Latched request.
   logic [3:0]  act_ff, act_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] pos_ff, pos_in, dur_ff, dur_in;
   logic [7:0]  tag_ff, tag_in;

   // Tables.
   logic        ev_valid_ff [EVENT_SLOTS];
   logic        ev_valid_in [EVENT_SLOTS];
   logic [15:0] ev_id_ff    [EVENT_SLOTS];
   logic [15:0] ev_id_in    [EVENT_SLOTS];
   logic [31:0] ev_pos_ff   [EVENT_SLOTS];
   logic [31:0] ev_pos_in   [EVENT_SLOTS];
   logic        done_ff     [EVENT_SLOTS];
   logic        done_in     [EVENT_SLOTS];
   logic        oo_valid_ff [ONE_OFF_SLOTS];
   logic        oo_valid_in [ONE_OFF_SLOTS];
   logic [31:0] oo_pos_ff   [ONE_OFF_SLOTS];
   logic [31:0] oo_pos_in   [ONE_OFF_SLOTS];
   logic [7:0]  oo_tag_ff   [ONE_OFF_SLOTS];
   logic [7:0]  oo_tag_in   [ONE_OFF_SLOTS];

   // Position state.
   logic [31:0] cur_ff, cur_in, fh_pos_ff, fh_pos_in;
   logic        playing_ff, playing_in, fh_valid_ff, fh_valid_in;

   // Scanner and its accumulators.
   logic [SW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in, free_ff, free_in;
   logic [EW-1:0] fidx_ff, fidx_in, freeidx_ff, freeidx_in;
   logic [31:0]   qpos_ff, qpos_in;
   logic          sel_ff, sel_in;
   logic [SW-1:0] sel_idx_ff, sel_idx_in;
   logic [31:0]   sel_pos_ff, sel_pos_in;
   logic [15:0]   sel_id_ff, sel_id_in;
   logic [7:0]    sel_tag_ff, sel_tag_in;
   logic          any_ff, any_in;
   logic          h1_ff, h1_in, h2_ff, h2_in, ho_ff, ho_in;
   logic [31:0]   b1_ff, b1_in, b2_ff, b2_in, bo_ff, bo_in;

   // Position change and remainder unit.
   logic [32:0] target_ff, target_in, num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  mcnt_ff, mcnt_in;

   // Status bookkeeping.
   logic        ok_ff, ok_in;
   logic [15:0] rid_ff, rid_in;
   logic [32:0] best_ff, best_in;
   logic        have_ff, have_in;

   // Result registers.
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [7:0]  rsp_tag_ff, rsp_tag_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in, rsp_ttn_ff, rsp_ttn_in;
   logic        rsp_play_ff, rsp_play_in, rsp_last_ff, rsp_last_in;

   // Views of the slot under the scanner.
   logic          first, scan_last, ev_in_range, oo_in_range, ev_v, oo_v, skip_here;
   logic [EW-1:0] e;
   logic [OW-1:0] o;
   logic [31:0]   ep, op_pos, lo;
   logic [15:0]   eid;
   logic [7:0]    otag;
   logic          f0, fr0, s0, a0, g1, g2, go;
   logic [32:0]   loop_end, rem_try, mod_sum, ev_best, next_gap;
   logic          ev_have, pos_same, pos_wrap;
   logic          ofree;
   logic [OW-1:0] ofree_idx;

   assign eff_len     = (len_ff == 32'd0) ? 32'd1 : len_ff;
   assign first       = (idx_ff == '0);
   assign scan_last   = (idx_ff == SCAN_LAST);
   assign e           = idx_ff[EW-1:0];
   assign o           = idx_ff[OW-1:0];
   assign ev_in_range = ({1'b0, idx_ff} < (SW+1)'(EVENT_SLOTS));
   assign oo_in_range = ({1'b0, idx_ff} < (SW+1)'(ONE_OFF_SLOTS));
   assign ev_v        = ev_in_range && ev_valid_ff[e];
   assign oo_v        = oo_in_range && oo_valid_ff[o];
   assign ep          = ev_pos_ff[e];
   assign eid         = ev_id_ff[e];
   assign op_pos      = oo_pos_ff[o];
   assign otag        = oo_tag_ff[o];
   assign skip_here   = fh_valid_ff && (fh_pos_ff == cur_ff);
   assign lo          = any_ff ? cur_ff : begin_ff;
   assign loop_end    = {1'b0, begin_ff} + {1'b0, eff_len};
   assign pos_same    = (target_ff == {1'b0, cur_ff});
   assign pos_wrap    = looping_ff && (target_ff >= loop_end);
   assign rem_try     = {rem_ff, num_ff[32]};
   assign mod_sum     = {1'b0, begin_ff} + {1'b0, rem_ff};
   assign next_gap    = best_ff - {1'b0, cur_ff};

   assign stat.playing   = playing_ff;
   assign stat.scan_last = scan_last;
   assign stat.mod_last  = (mcnt_ff == MOD_LAST);
   assign stat.sel_found = sel_ff;
   assign stat.skip_here = skip_here;
   assign stat.any_ahead = any_ff;
   assign stat.looping   = looping_ff;
   assign stat.pos_same  = pos_same;
   assign stat.pos_wrap  = pos_wrap;

   // Lowest free one-off slot.
   always_comb begin
      ofree     = 1'b0;
      ofree_idx = '0;
      for (int i = ONE_OFF_SLOTS - 1; i >= 0; i--) begin
         if (!oo_valid_ff[i]) begin
            ofree     = 1'b1;
            ofree_idx = OW'(i);
         end
      end
   end

   always_comb begin
      begin_in   = begin_ff;
      len_in     = len_ff;
      looping_in = looping_ff;
      act_in = act_ff; id_in = id_ff; pos_in = pos_ff; dur_in = dur_ff; tag_in = tag_ff;
      ev_valid_in = ev_valid_ff;
      ev_id_in    = ev_id_ff;
      ev_pos_in   = ev_pos_ff;
      done_in     = done_ff;
      oo_valid_in = oo_valid_ff;
      oo_pos_in   = oo_pos_ff;
      oo_tag_in   = oo_tag_ff;
      cur_in = cur_ff; playing_in = playing_ff;
      fh_valid_in = fh_valid_ff; fh_pos_in = fh_pos_ff;
      idx_in = idx_ff;
      found_in = found_ff; fidx_in = fidx_ff; qpos_in = qpos_ff;
      free_in = free_ff; freeidx_in = freeidx_ff;
      sel_in = sel_ff; sel_idx_in = sel_idx_ff; sel_pos_in = sel_pos_ff;
      sel_id_in = sel_id_ff; sel_tag_in = sel_tag_ff;
      any_in = any_ff;
      h1_in = h1_ff; b1_in = b1_ff; h2_in = h2_ff; b2_in = b2_ff; ho_in = ho_ff; bo_in = bo_ff;
      target_in = target_ff; num_in = num_ff; rem_in = rem_ff; mcnt_in = mcnt_ff;
      ok_in = ok_ff; rid_in = rid_ff; best_in = best_ff; have_in = have_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in = rsp_kind_ff; rsp_ok_in = rsp_ok_ff; rsp_id_in = rsp_id_ff;
      rsp_tag_in = rsp_tag_ff; rsp_pos_in = rsp_pos_ff; rsp_ttn_in = rsp_ttn_ff;
      rsp_play_in = rsp_play_ff; rsp_last_in = rsp_last_ff;
      f0 = 1'b0; fr0 = 1'b0; s0 = 1'b0; a0 = 1'b0; g1 = 1'b0; g2 = 1'b0; go = 1'b0;
      ev_have = 1'b0; ev_best = '0;

      if (csr_write_enable) begin
         case (csr_index)
            REG_LOOP_BEGIN:  begin_in   = csr_write_data;
            REG_LOOP_LENGTH: len_in     = csr_write_data;
            REG_LOOPING:     looping_in = csr_write_data[0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LATCH: begin
            act_in = req_action; id_in = req_event_id; pos_in = req_position;
            dur_in = req_duration; tag_in = req_tag;
         end
         OP_SCAN: begin
            idx_in = scan_last ? '0 : idx_ff + SW'(1);
            case (cmd.mode)
               SCAN_FIND: begin
                  f0  = first ? 1'b0 : found_ff;
                  fr0 = first ? 1'b0 : free_ff;
                  found_in = f0;
                  free_in  = fr0;
                  if (!f0 && ev_v && eid == id_ff && id_ff != 16'd0) begin
                     found_in = 1'b1; fidx_in = e; qpos_in = ep;
                  end
                  if (!fr0 && ev_in_range && !ev_valid_ff[e]) begin
                     free_in = 1'b1; freeidx_in = e;
                  end
               end
               SCAN_OOSEL: begin
                  s0 = first ? 1'b0 : sel_ff;
                  sel_in = s0;
                  if (oo_v && op_pos <= cur_ff && (!s0 || op_pos < sel_pos_ff)) begin
                     sel_in = 1'b1; sel_idx_in = idx_ff; sel_pos_in = op_pos;
                     sel_tag_in = otag;
                  end
               end
               SCAN_AHEAD: begin
                  a0 = first ? 1'b0 : any_ff;
                  any_in = a0 || (ev_v && ep >= cur_ff);
                  if (ev_in_range) done_in[e] = 1'b0;
               end
               SCAN_EVSEL: begin
                  s0 = first ? 1'b0 : sel_ff;
                  sel_in = s0;
                  if (ev_v && !done_ff[e] && ep >= lo && ep <= cur_ff &&
                      (!s0 || ep < sel_pos_ff || (ep == sel_pos_ff && eid < sel_id_ff))) begin
                     sel_in = 1'b1; sel_idx_in = idx_ff; sel_pos_in = ep; sel_id_in = eid;
                  end
               end
               SCAN_NEXT: begin
                  g1 = first ? 1'b0 : h1_ff;
                  g2 = first ? 1'b0 : h2_ff;
                  go = first ? 1'b0 : ho_ff;
                  h1_in = g1; h2_in = g2; ho_in = go;
                  if (ev_v && (ep > cur_ff || (ep == cur_ff && !skip_here)) &&
                      (!g1 || ep < b1_ff)) begin
                     h1_in = 1'b1; b1_in = ep;
                  end
                  if (ev_v && ep >= begin_ff && (!g2 || ep < b2_ff)) begin
                     h2_in = 1'b1; b2_in = ep;
                  end
                  if (oo_v && (!go || op_pos < bo_ff)) begin
                     ho_in = 1'b1; bo_in = op_pos;
                  end
               end
               default: ;
            endcase
         end
         OP_APPLY: begin
            ok_in  = 1'b1;
            rid_in = 16'd0;
            case (act_ff)
               ACT_ADD: begin
                  rid_in = id_ff;
                  ok_in  = (id_ff != 16'd0) && !found_ff && free_ff;
                  if ((id_ff != 16'd0) && !found_ff && free_ff) begin
                     ev_valid_in[freeidx_ff] = 1'b1;
                     ev_id_in[freeidx_ff]    = id_ff;
                     ev_pos_in[freeidx_ff]   = pos_ff;
                  end
               end
               ACT_REMOVE: begin
                  rid_in = id_ff;
                  ok_in  = found_ff;
                  if (found_ff) ev_valid_in[fidx_ff] = 1'b0;
               end
               ACT_MOVE: begin
                  rid_in = id_ff;
                  ok_in  = found_ff;
                  if (found_ff) ev_pos_in[fidx_ff] = pos_ff;
               end
               ACT_ONE_OFF: begin
                  ok_in = playing_ff && (pos_ff >= cur_ff) && ofree;
                  if (playing_ff && (pos_ff >= cur_ff) && ofree) begin
                     oo_valid_in[ofree_idx] = 1'b1;
                     oo_pos_in[ofree_idx]   = pos_ff;
                     oo_tag_in[ofree_idx]   = tag_ff;
                  end
               end
               ACT_SET:    target_in = {1'b0, pos_ff};
               ACT_UPDATE: target_in = {1'b0, cur_ff} + {1'b0, dur_ff};
               ACT_START:  playing_in = 1'b1;
               ACT_STOP: begin
                  playing_in = 1'b0;
                  for (int i = 0; i < ONE_OFF_SLOTS; i++) oo_valid_in[i] = 1'b0;
               end
               ACT_QUERY: begin
                  rid_in = id_ff;
                  ok_in  = found_ff;
               end
               default: ok_in = 1'b0;
            endcase
         end
         OP_SETPOS: begin
            if (!pos_same) begin
               fh_valid_in = 1'b0;
               for (int i = 0; i < ONE_OFF_SLOTS; i++) begin
                  if (oo_valid_ff[i] && ({1'b0, oo_pos_ff[i]} < target_ff)) begin
                     oo_valid_in[i] = 1'b0;
                  end else if (oo_valid_ff[i] && pos_wrap) begin
                     oo_pos_in[i] = begin_ff;
                  end
               end
               if (pos_wrap) begin
                  num_in  = target_ff - {1'b0, begin_ff};
                  rem_in  = 32'd0;
                  mcnt_in = 6'd0;
               end else begin
                  cur_in = target_ff[32] ? ALL32 : target_ff[31:0];
               end
            end
         end
         OP_MOD: begin
            // Restoring remainder, one numerator bit per cycle.
            rem_in  = (rem_try >= {1'b0, eff_len}) ? 32'(rem_try - {1'b0, eff_len})
                                                  : rem_try[31:0];
            num_in  = {num_ff[31:0], 1'b0};
            mcnt_in = mcnt_ff + 6'd1;
         end
         OP_MOD_FIN: begin
            cur_in = mod_sum[32] ? ALL32 : mod_sum[31:0];
         end
         OP_FIRE_OO: begin
            oo_valid_in[sel_idx_ff[OW-1:0]] = 1'b0;
            rsp_strobe_in = 1'b1; rsp_kind_in = KIND_ONE_OFF; rsp_ok_in = 1'b1;
            rsp_id_in = 16'd0; rsp_tag_in = sel_tag_ff; rsp_pos_in = cur_ff;
            rsp_ttn_in = 32'd0; rsp_play_in = playing_ff; rsp_last_in = 1'b0;
         end
         OP_FIRE_EV: begin
            done_in[sel_idx_ff[EW-1:0]] = 1'b1;
            rsp_strobe_in = 1'b1; rsp_kind_in = KIND_EVENT; rsp_ok_in = 1'b1;
            rsp_id_in = sel_id_ff; rsp_tag_in = 8'd0; rsp_pos_in = cur_ff;
            rsp_ttn_in = 32'd0; rsp_play_in = playing_ff; rsp_last_in = 1'b0;
         end
         OP_TRIG_END: begin
            fh_valid_in = 1'b1;
            fh_pos_in   = cur_ff;
            ok_in       = 1'b1;
            rid_in      = 16'd0;
         end
         OP_NEXT_SUM: begin
            // With no event ahead, a looping sequencer looks one loop further.
            ev_have = h1_ff || (looping_ff && h2_ff);
            ev_best = h1_ff ? {1'b0, b1_ff} : ({1'b0, b2_ff} + {1'b0, eff_len});
            have_in = ev_have || ho_ff;
            if (!ev_have || (ho_ff && ({1'b0, bo_ff} < ev_best))) begin
               best_in = {1'b0, bo_ff};
            end else begin
               best_in = ev_best;
            end
         end
         OP_STATUS: begin
            rsp_strobe_in = 1'b1; rsp_kind_in = KIND_STATUS; rsp_ok_in = ok_ff;
            rsp_id_in = rid_ff; rsp_tag_in = 8'd0;
            rsp_pos_in = ((act_ff == ACT_QUERY) && found_ff) ? qpos_ff : cur_ff;
            rsp_play_in = playing_ff; rsp_last_in = 1'b1;
            if (!playing_ff || !have_ff) begin
               rsp_ttn_in = ALL32;
            end else if (best_ff <= {1'b0, cur_ff}) begin
               rsp_ttn_in = 32'd0;
            end else begin
               rsp_ttn_in = (next_gap >= {1'b0, ALL32}) ? NEAR_ALL : next_gap[31:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_ff      <= 32'd0;
         len_ff        <= 32'd65536;
         looping_ff    <= 1'b0;
         cur_ff        <= 32'd0;
         playing_ff    <= 1'b0;
         fh_valid_ff   <= 1'b0;
         fh_pos_ff     <= 32'd0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < EVENT_SLOTS; i++) ev_valid_ff[i] <= 1'b0;
         for (int i = 0; i < ONE_OFF_SLOTS; i++) oo_valid_ff[i] <= 1'b0;
      end else begin
         begin_ff      <= begin_in;
         len_ff        <= len_in;
         looping_ff    <= looping_in;
         cur_ff        <= cur_in;
         playing_ff    <= playing_in;
         fh_valid_ff   <= fh_valid_in;
         fh_pos_ff     <= fh_pos_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
         ev_valid_ff   <= ev_valid_in;
         oo_valid_ff   <= oo_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; id_ff <= id_in; pos_ff <= pos_in; dur_ff <= dur_in; tag_ff <= tag_in;
      ev_id_ff  <= ev_id_in;
      ev_pos_ff <= ev_pos_in;
      done_ff   <= done_in;
      oo_pos_ff <= oo_pos_in;
      oo_tag_ff <= oo_tag_in;
      found_ff <= found_in; fidx_ff <= fidx_in; qpos_ff <= qpos_in;
      free_ff <= free_in; freeidx_ff <= freeidx_in;
      sel_ff <= sel_in; sel_idx_ff <= sel_idx_in; sel_pos_ff <= sel_pos_in;
      sel_id_ff <= sel_id_in; sel_tag_ff <= sel_tag_in;
      any_ff <= any_in;
      h1_ff <= h1_in; b1_ff <= b1_in; h2_ff <= h2_in; b2_ff <= b2_in;
      ho_ff <= ho_in; bo_ff <= bo_in;
      target_ff <= target_in; num_ff <= num_in; rem_ff <= rem_in; mcnt_ff <= mcnt_in;
      ok_ff <= ok_in; rid_ff <= rid_in; best_ff <= best_in; have_ff <= have_in;
      rsp_kind_ff <= rsp_kind_in; rsp_ok_ff <= rsp_ok_in; rsp_id_ff <= rsp_id_in;
      rsp_tag_ff <= rsp_tag_in; rsp_pos_ff <= rsp_pos_in; rsp_ttn_ff <= rsp_ttn_in;
      rsp_play_ff <= rsp_play_in; rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_fired_id     = rsp_id_ff;
   assign rsp_fired_tag    = rsp_tag_ff;
   assign rsp_now_position = rsp_pos_ff;
   assign rsp_time_to_next = rsp_ttn_ff;
   assign rsp_is_playing   = rsp_play_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== src/looping_event_sequencer.sv =====
// ---------------------------------------------------------------------------
// Looping event sequencer
// Timed scheduler of table events and one-offs on a Q16.16 beat position.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until its status result has been presented. Results appear one per strobe
// cycle and must be taken as they come. Every table search walks the slots one
// per cycle, S = max(EVENT_SLOTS, ONE_OFF_SLOTS) slots a pass, so the cost is
// set by that scanner: start, stop, one-off and unknown actions take one pass,
// add, remove, move and query two; set position, and update while playing, add
// a position step and, when the loop wraps, the serial remainder. A trigger
// that fires j one-offs and k table events takes up to j + k + 4 passes.
`timescale 1ns / 1ps

module looping_event_sequencer
   import les_pkg::*;
#(
   parameter int EVENT_SLOTS   = EVENT_SLOTS_DEF,
   parameter int ONE_OFF_SLOTS = ONE_OFF_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_action,
   input  logic [15:0] req_event_id,
   input  logic [31:0] req_position,
   input  logic [31:0] req_duration,
   input  logic [7:0]  req_tag,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic        rsp_ok,
   output logic [15:0] rsp_fired_id,
   output logic [7:0]  rsp_fired_tag,
   output logic [31:0] rsp_now_position,
   output logic [31:0] rsp_time_to_next,
   output logic        rsp_is_playing,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   les_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd)
   );

   les_datapath #(
      .EVENT_SLOTS   (EVENT_SLOTS),
      .ONE_OFF_SLOTS (ONE_OFF_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_event_id     (req_event_id),
      .req_position     (req_position),
      .req_duration     (req_duration),
      .req_tag          (req_tag),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_ok           (rsp_ok),
      .rsp_fired_id     (rsp_fired_id),
      .rsp_fired_tag    (rsp_fired_tag),
      .rsp_now_position (rsp_now_position),
      .rsp_time_to_next (rsp_time_to_next),
      .rsp_is_playing   (rsp_is_playing),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== src/les_checker.sv =====
// ---------------------------------------------------------------------------
// Sequencer port checker
// Watches the top-level ports for the ordering of results within a
// transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module les_checker
   import les_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_kind,
   input logic        rsp_ok,
   input logic [31:0] rsp_time_to_next,
   input logic        rsp_last
);

   // An accepted transaction keeps the block busy until its status goes out.
   `ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
   // The status result closes the transaction and leaves the block free.
   `ASSERT_HOLDS(a_status_ends_busy, rsp_strobe && rsp_last, !busy)
   // Only the status result carries the last flag.
   `ASSERT_HOLDS(a_last_is_status, rsp_strobe, rsp_last == (rsp_kind == KIND_STATUS))
   // Fire results always succeed and report no distance.
   `ASSERT_HOLDS(a_fire_fields, rsp_strobe && !rsp_last,
                 rsp_ok && (rsp_time_to_next == 32'd0))
   // No result follows a status result directly.
   `ASSERT_NEXT(a_gap_after_status, rsp_strobe && rsp_last, !rsp_strobe)

endmodule

bind looping_event_sequencer les_checker u_les_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_kind         (rsp_kind),
   .rsp_ok           (rsp_ok),
   .rsp_time_to_next (rsp_time_to_next),
   .rsp_last         (rsp_last)
);
